[src/hpa_pkg.sv]
package hpa_pkg;

   localparam logic [15:0] SIGN_MASK  = 16'h8000;
   localparam logic [15:0] EXP_MASK   = 16'h7c00;
   localparam logic [15:0] FRAC_MASK  = 16'h03ff;
   localparam logic [10:0] HIDDEN_BIT = 11'd1024;
   localparam logic [15:0] QNAN_BITS  = 16'h7e00;
   localparam logic [15:0] MAX_FINITE = 16'h7bff;
   localparam logic [4:0]  EXP_MAX    = 5'd31;

   // Unpacked operand pair after special-case screening and ordering.
   typedef struct packed {
      logic        special;    // result already known
      logic [15:0] spec_bits;
      logic        sign;
      logic [4:0]  exp_large;
      logic [10:0] mant_large;
      logic [10:0] mant_small;
      logic        subtract;
      logic [4:0]  diff;
   } align_type;

   // Raw sum before normalisation.
   typedef struct packed {
      logic        special;
      logic [15:0] spec_bits;
      logic        sign;
      logic [4:0]  exp_large;
      logic [11:0] mant;
   } add_type;

   // Normalised magnitude ready for range checks.
   typedef struct packed {
      logic        special;
      logic [15:0] spec_bits;
      logic        sign;
      logic signed [6:0] exp_norm;
      logic [9:0]  frac;
   } norm_type;

   function automatic logic [3:0] lead_shift(input logic [11:0] m);
      logic [3:0] sh;
      sh = 4'd0;
      for (int i = 0; i <= 10; i++) begin
         if (m[i]) sh = 4'(10 - i);
      end
      return sh;
   endfunction

endpackage

[src/hpa_unpack.sv]
module hpa_unpack (
   input  logic [15:0]              operand_a,
   input  logic [15:0]              operand_b,
   output hpa_pkg::align_type       unpacked
);
   import hpa_pkg::*;

   logic [4:0] ea, eb;
   logic [9:0] fa, fb;
   logic       sa, sb, a_nan, b_nan, a_inf, b_inf, a_ge;

   always_comb begin
      ea    = operand_a[14:10];
      eb    = operand_b[14:10];
      fa    = operand_a[9:0];
      fb    = operand_b[9:0];
      sa    = operand_a[15];
      sb    = operand_b[15];
      a_nan = (ea == EXP_MAX) && (fa != 10'd0);
      b_nan = (eb == EXP_MAX) && (fb != 10'd0);
      a_inf = (ea == EXP_MAX);
      b_inf = (eb == EXP_MAX);
      a_ge  = operand_a[14:0] >= operand_b[14:0];

      unpacked           = '0;
      unpacked.special   = 1'b1;
      if (a_nan || b_nan) begin
         unpacked.spec_bits = QNAN_BITS;
      end else if (a_inf || b_inf) begin
         if (a_inf && b_inf && (sa != sb)) unpacked.spec_bits = QNAN_BITS;
         else if (a_inf)                   unpacked.spec_bits = operand_a;
         else                              unpacked.spec_bits = operand_b;
      end else if ((ea == 5'd0) && (eb == 5'd0)) begin
         unpacked.spec_bits = operand_a & operand_b & SIGN_MASK;
      end else if (ea == 5'd0) begin
         unpacked.spec_bits = operand_b;
      end else if (eb == 5'd0) begin
         unpacked.spec_bits = operand_a;
      end else begin
         unpacked.special  = 1'b0;
         unpacked.subtract = sa ^ sb;
         if (a_ge) begin
            unpacked.sign       = sa;
            unpacked.exp_large  = ea;
            unpacked.mant_large = {1'b1, fa};
            unpacked.mant_small = {1'b1, fb};
            unpacked.diff       = ea - eb;
         end else begin
            unpacked.sign       = sb;
            unpacked.exp_large  = eb;
            unpacked.mant_large = {1'b1, fb};
            unpacked.mant_small = {1'b1, fa};
            unpacked.diff       = eb - ea;
         end
      end
   end

endmodule

[src/hpa_addsub.sv]
module hpa_addsub (
   input  hpa_pkg::align_type unpacked,
   output hpa_pkg::add_type   summed
);
   import hpa_pkg::*;

   logic [10:0] ms;

   always_comb begin
      ms = (unpacked.diff >= 5'd11) ? 11'd0 : (unpacked.mant_small >> unpacked.diff);
      summed.special   = unpacked.special;
      summed.spec_bits = unpacked.spec_bits;
      summed.sign      = unpacked.sign;
      summed.exp_large = unpacked.exp_large;
      if (unpacked.subtract) summed.mant = {1'b0, unpacked.mant_large} - {1'b0, ms};
      else                   summed.mant = {1'b0, unpacked.mant_large} + {1'b0, ms};
      // Exact cancellation gives positive zero.
      if (!unpacked.special && unpacked.subtract && (unpacked.mant_large == ms)) begin
         summed.special   = 1'b1;
         summed.spec_bits = 16'd0;
      end
   end

endmodule

[src/hpa_normalise.sv]
module hpa_normalise (
   input  hpa_pkg::add_type  summed,
   output hpa_pkg::norm_type normed
);
   import hpa_pkg::*;

   logic [3:0]  sh;
   logic [11:0] m;

   always_comb begin
      sh               = lead_shift(summed.mant);
      normed.special   = summed.special;
      normed.spec_bits = summed.spec_bits;
      normed.sign      = summed.sign;
      if (summed.mant[11]) begin
         m               = summed.mant >> 1;
         normed.exp_norm = $signed({2'b00, summed.exp_large}) + 7'sd1;
      end else begin
         m               = summed.mant << sh;
         normed.exp_norm = $signed({2'b00, summed.exp_large}) - $signed({3'b000, sh});
      end
      normed.frac = m[9:0];
   end

endmodule

[src/half_precision_adder.sv]
// binary16 adder with truncation toward zero.
// Input channel: req_valid/req_ready carry one beat of req_operand_a and
// req_operand_b. Result channel: rsp_valid/rsp_ready carry rsp_sum_bits and
// rsp_overflowed, one result beat for every input beat, in order.
// The datapath has four register stages: unpack and order, align and
// add, normalise, then range check into the output register. One beat is
// taken every cycle while the receiver keeps up.
// NaN gives 0x7E00, subnormals read as zero, underflow flushes to signed
// zero and overflow saturates to the largest finite value with
// rsp_overflowed set.
// When the receiver stalls, the whole pipeline holds and req_ready falls only
// when the output stage is full and would not drain; no beat is lost.
// Reset clears every valid bit and holds req_ready low; the block takes beats
// as soon as reset is released.
module half_precision_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sum_bits,
   output logic        rsp_overflowed
);
   import hpa_pkg::*;

   logic      advance;
   align_type s1_in, s1_ff;
   add_type   s2_in, s2_ff;
   norm_type  s3_in, s3_ff;
   logic      v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0] sum_in, sum_ff;
   logic        ovf_in, ovf_ff;

   // Global enable: stages move together while the output can drain.
   assign advance   = !v4_ff || rsp_ready;
   assign req_ready = advance && !reset;

   hpa_unpack u_unpack (
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .unpacked  (s1_in)
   );

   hpa_addsub u_addsub (
      .unpacked (s1_ff),
      .summed   (s2_in)
   );

   hpa_normalise u_normalise (
      .summed (s2_ff),
      .normed (s3_in)
   );

   always_comb begin
      ovf_in = 1'b0;
      if (s3_ff.special) begin
         sum_in = s3_ff.spec_bits;
      end else if (s3_ff.exp_norm < 7'sd1) begin
         sum_in = {s3_ff.sign, 15'd0};
      end else if (s3_ff.exp_norm > 7'sd30) begin
         sum_in = {s3_ff.sign, MAX_FINITE[14:0]};
         ovf_in = 1'b1;
      end else begin
         sum_in = {s3_ff.sign, s3_ff.exp_norm[4:0], s3_ff.frac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid      = v4_ff;
   assign rsp_sum_bits   = sum_ff;
   assign rsp_overflowed = ovf_ff;

endmodule

[tb/sv/half_precision_adder_test.sv]
module half_precision_adder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hpa_pkg::*;

   localparam int RANDOM_BEATS = 1750;
   localparam int CALM_TAIL    = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DIRECTED_ROWS = 24;

   typedef struct {
      logic [15:0] opa;
      logic [15:0] opb;
      logic        known;
      logic [15:0] sum;
      logic        ovf;
   } stim_row_t;

   typedef struct {
      logic [15:0] sum;
      logic        ovf;
   } fp_sum_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_operand_a = '0;
   logic [15:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sum_bits;
   logic        rsp_overflowed;

   fp_sum_t     sums_pending[$];
   int          errors = 0;
   int          sums_seen = 0;
   int          idle_count = 0;
   int          ovf_seen = 0;
   bit          calm = 1'b0;
   bit          stim_done = 1'b0;
   stim_row_t   rows[DIRECTED_ROWS];

   always #4 clock = ~clock;

   half_precision_adder dut (.*);

   // Truncating binary16 sum; subnormals read as zero.
   function automatic fp_sum_t fp16_add(input logic [15:0] a, input logic [15:0] b);
      fp_sum_t     r;
      logic [4:0]  ea, eb, el, es, gap;
      logic [10:0] ml, ms;
      logic [11:0] mag;
      logic        sl, ss;
      int          ex;
      ea = a[14:10];
      eb = b[14:10];
      r.ovf = 1'b0;
      if ((ea == EXP_MAX && a[9:0] != 0) || (eb == EXP_MAX && b[9:0] != 0)) begin
         r.sum = QNAN_BITS;
         return r;
      end
      if (ea == EXP_MAX || eb == EXP_MAX) begin
         if (ea == EXP_MAX && eb == EXP_MAX && a[15] != b[15]) r.sum = QNAN_BITS;
         else r.sum = (ea == EXP_MAX) ? a : b;
         return r;
      end
      if (ea == 0 && eb == 0) begin
         r.sum = (a & b) & SIGN_MASK;
         return r;
      end
      if (ea == 0) begin
         r.sum = b;
         return r;
      end
      if (eb == 0) begin
         r.sum = a;
         return r;
      end
      if (a[14:0] >= b[14:0]) begin
         el = ea; ml = {1'b1, a[9:0]}; sl = a[15];
         es = eb; ms = {1'b1, b[9:0]}; ss = b[15];
      end else begin
         el = eb; ml = {1'b1, b[9:0]}; sl = b[15];
         es = ea; ms = {1'b1, a[9:0]}; ss = a[15];
      end
      gap = el - es;
      ms = (gap >= 11) ? 11'd0 : ms >> gap;
      ex = el;
      if (sl == ss) mag = ml + ms;
      else mag = ml - ms;
      if (mag == 0) begin
         r.sum = 16'h0000;
         return r;
      end
      if (mag[11]) begin
         mag = mag >> 1;
         ex++;
      end
      while (!mag[10]) begin
         mag = mag << 1;
         ex--;
      end
      if (ex < 1) r.sum = {sl, 15'd0};
      else if (ex > 30) begin
         r.sum = {sl, MAX_FINITE[14:0]};
         r.ovf = 1'b1;
      end else r.sum = {sl, 5'(ex), mag[9:0]};
      return r;
   endfunction

   task automatic send_beat(input logic [15:0] a, input logic [15:0] b);
      req_operand_a <= a;
      req_operand_b <= b;
      req_valid <= 1'b1;
      sums_pending.push_back(fp16_add(a, b));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random beats: normal numbers with nearby exponents most of the time.
   function automatic logic [15:0] pick_operand(input logic [4:0] near);
      int k;
      logic [4:0] e;
      k = $urandom_range(0, 19);
      if (k == 0) return 16'($urandom);
      if (k == 1) return {1'($urandom), 5'd31, 10'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
      if (k == 2) return {1'($urandom), 5'd0, 10'($urandom_range(0, 1) ? 0 : $urandom)};
      if (k == 3) return {1'($urandom), 5'($urandom_range(27, 30)), 10'($urandom)};
      e = 5'(int'(near) + $urandom_range(0, 6) - 3);
      if (e == 0 || e == 31) e = near;
      return {1'($urandom), e, 10'($urandom)};
   endfunction

   initial begin
      rows = '{
         '{16'h0000, 16'h0000, 1, 16'h0000, 0},
         '{16'h8000, 16'h8000, 1, 16'h8000, 0},
         '{16'h8000, 16'h0000, 1, 16'h0000, 0},
         '{16'h0000, 16'h3c00, 1, 16'h3c00, 0},
         '{16'hbc00, 16'h8000, 1, 16'hbc00, 0},
         '{16'h03ff, 16'h4000, 1, 16'h4000, 0},
         '{16'h7e01, 16'h3c00, 1, 16'h7e00, 0},
         '{16'h3c00, 16'hfc01, 1, 16'h7e00, 0},
         '{16'h7c00, 16'hfc00, 1, 16'h7e00, 0},
         '{16'h7c00, 16'h7c00, 1, 16'h7c00, 0},
         '{16'hfc00, 16'h3c00, 1, 16'hfc00, 0},
         '{16'h3c00, 16'h7c00, 1, 16'h7c00, 0},
         '{16'h3c00, 16'hbc00, 1, 16'h0000, 0},
         '{16'hc500, 16'h4500, 1, 16'h0000, 0},
         '{16'h7bff, 16'h7bff, 1, 16'h7bff, 1},
         '{16'hfbff, 16'hf800, 1, 16'hfbff, 1},
         '{16'h3c00, 16'h3c00, 1, 16'h4000, 0},
         '{16'h7800, 16'h0400, 0, 0, 0},
         '{16'h0401, 16'h8400, 0, 0, 0},
         '{16'h0800, 16'h8401, 0, 0, 0},
         '{16'h3c01, 16'hbc00, 0, 0, 0},
         '{16'h4000, 16'h3401, 0, 0, 0},
         '{16'hffff, 16'h0001, 0, 0, 0},
         '{16'h5555, 16'haaaa, 0, 0, 0}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         if (rows[i].known) begin
            fp_sum_t p;
            p = fp16_add(rows[i].opa, rows[i].opb);
            if (p.sum !== rows[i].sum || p.ovf !== rows[i].ovf)
               $error("table row %0d disagrees with predictor: %h/%b vs %h/%b",
                      i, rows[i].sum, rows[i].ovf, p.sum, p.ovf);
         end
         send_beat(rows[i].opa, rows[i].opb);
      end
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         logic [4:0] near;
         if (n == RANDOM_BEATS - CALM_TAIL) calm = 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         near = 5'($urandom_range(1, 30));
         send_beat(pick_operand(near), pick_operand(near));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (calm) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 7) == 0) rsp_ready <= ~rsp_ready;
      else if (!rsp_ready && $urandom_range(0, 3) == 0) rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      fp_sum_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         sums_seen++;
         if (rsp_overflowed) ovf_seen++;
         if (sums_pending.size() == 0) begin
            $error("sum beat %h with nothing outstanding", rsp_sum_bits);
            errors++;
         end else begin
            want = sums_pending.pop_front();
            if (rsp_sum_bits !== want.sum) begin
               $error("sum_bits expected %h actual %h", want.sum, rsp_sum_bits);
               errors++;
            end
            if (rsp_overflowed !== want.ovf) begin
               $error("overflowed expected %b actual %b", want.ovf, rsp_overflowed);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted beat on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (sums_pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d sum beats, %0d of them saturated, with stalls on both sides",
               sums_seen, ovf_seen);
      if (errors == 0 && sums_pending.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
